>>> design/double_knock_detector_unit_assert.svh
// Assertion helpers for the datapath RTL, clocked on i_clk and disabled in reset.
`ifndef DOUBLE_KNOCK_DETECTOR_UNIT_ASSERT_SVH
`define DOUBLE_KNOCK_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DKD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DKD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dkd_pkg.sv
`default_nettype none

package dkd_pkg;

    localparam int MAX_SLICE_SAMPLES_DEF = 1024;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int ENERGY_W = 16;
    localparam int THR_W    = 23;
    localparam int PROD_W   = 24;
    localparam int MIN_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [MIN_W-1:0] MIN_NONE = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BURST    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN     = 3'd6;

    localparam logic [15:0] FLOOR_WINDOW_RST = 16'd1000;
    localparam logic [7:0]  GAIN_RST         = 8'd8;
    localparam logic [15:0] THR_MIN_RST      = 16'd300;
    localparam logic [15:0] MAX_BURST_RST    = 16'd200;
    localparam logic [15:0] MIN_GAP_RST      = 16'd100;
    localparam logic [15:0] MAX_GAP_RST      = 16'd800;
    localparam logic [15:0] COOLDOWN_RST     = 16'd1500;

    typedef enum logic [1:0] {
        KS_IDLE     = 2'd0,
        KS_ARMED    = 2'd1,
        KS_COOLDOWN = 2'd2
    } t_knock_state;

    typedef enum logic [2:0] {
        S_ACCEPT,
        S_DIVIDE,
        S_WINDOW,
        S_THRESH,
        S_DECIDE
    } t_ctl_state;

    typedef struct packed {
        logic [15:0] floor_window_ms;
        logic [7:0]  threshold_gain;
        logic [15:0] threshold_minimum;
        logic [15:0] max_burst_ms;
        logic [15:0] min_gap_ms;
        logic [15:0] max_gap_ms;
        logic [15:0] cooldown_ms;
    } t_cfg;

    typedef struct packed {
        logic accum;     // add the accepted sample
        logic start;     // last sample: latch slice data, prime divider
        logic div_step;
        logic win_upd;
        logic thr_calc;
        logic finish;    // recognizer step, load result, clear accumulator
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> design/dkd_if.sv
`default_nettype none

interface dkd_in_if;
    import dkd_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_in_slice;
    logic [TIME_W-1:0]          time_ms;
    logic                       chat_idle;

    modport source (output valid, sample, last_in_slice, time_ms, chat_idle, input ready);
    modport sink (input valid, sample, last_in_slice, time_ms, chat_idle, output ready);
endinterface

interface dkd_out_if;
    import dkd_pkg::*;
    logic                valid;
    logic                ready;
    logic                knock_detected;
    logic [ENERGY_W-1:0] slice_energy;
    logic [THR_W-1:0]    hit_threshold;
    logic [1:0]          recognizer_state;

    modport source (output valid, knock_detected, slice_energy, hit_threshold,
                    recognizer_state, input ready);
    modport sink (input valid, knock_detected, slice_energy, hit_threshold,
                  recognizer_state, output ready);
endinterface

`default_nettype wire

>>> design/dkd_cfg_regs.sv
`default_nettype none

module dkd_cfg_regs
    import dkd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FLOOR_WINDOW: n_cfg.floor_window_ms   = i_cfg_data;
                CFG_GAIN:         n_cfg.threshold_gain    = i_cfg_data[7:0];
                CFG_THR_MIN:      n_cfg.threshold_minimum = i_cfg_data;
                CFG_MAX_BURST:    n_cfg.max_burst_ms      = i_cfg_data;
                CFG_MIN_GAP:      n_cfg.min_gap_ms        = i_cfg_data;
                CFG_MAX_GAP:      n_cfg.max_gap_ms        = i_cfg_data;
                CFG_COOLDOWN:     n_cfg.cooldown_ms       = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_window_ms   <= FLOOR_WINDOW_RST;
            r_cfg.threshold_gain    <= GAIN_RST;
            r_cfg.threshold_minimum <= THR_MIN_RST;
            r_cfg.max_burst_ms      <= MAX_BURST_RST;
            r_cfg.min_gap_ms        <= MIN_GAP_RST;
            r_cfg.max_gap_ms        <= MAX_GAP_RST;
            r_cfg.cooldown_ms       <= COOLDOWN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> design/dkd_ctrl.sv
`default_nettype none

module dkd_ctrl
    import dkd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_last,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_ACCEPT: if (i_in_valid && i_in_last) n_state = S_DIVIDE;
            S_DIVIDE: if (i_stat.div_done) n_state = S_WINDOW;
            S_WINDOW: n_state = S_THRESH;
            S_THRESH: n_state = S_DECIDE;
            S_DECIDE: if (i_stat.out_free) n_state = S_ACCEPT;
            default:  n_state = S_ACCEPT;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_ACCEPT: begin
                o_in_ready  = 1'b1;
                o_cmd.accum = i_in_valid;
                o_cmd.start = i_in_valid && i_in_last;
            end
            S_DIVIDE: o_cmd.div_step = 1'b1;
            S_WINDOW: o_cmd.win_upd  = 1'b1;
            S_THRESH: o_cmd.thr_calc = 1'b1;
            S_DECIDE: o_cmd.finish   = i_stat.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> design/dkd_datapath.sv
`default_nettype none

module dkd_datapath
    import dkd_pkg::*;
#(
    parameter int MAX_SLICE_SAMPLES = MAX_SLICE_SAMPLES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cfg                       i_cfg,
    input  wire t_dp_cmd                    i_cmd,
    output t_dp_stat                        o_stat,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic [TIME_W-1:0]          i_time_ms,
    input  wire logic                       i_chat_idle,
    dkd_out_if.source                       o_res
);

`include "double_knock_detector_unit_assert.svh"

    localparam int CNT_W  = $clog2(MAX_SLICE_SAMPLES + 1);
    localparam int SUM_W  = 15 + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    // accumulator doubles as the dividend / quotient shift register
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic [TIME_W-1:0] r_now;
    logic              r_chat;

    logic [ENERGY_W-1:0] r_nf;
    logic [MIN_W-1:0]    r_wmin;
    logic [TIME_W-1:0]   r_wstart;
    logic [PROD_W-1:0]   r_thr;
    t_knock_state        r_ks;
    logic                r_in_burst;
    logic [TIME_W-1:0]   r_bstart;
    logic [TIME_W-1:0]   r_lkt;

    logic                r_out_valid;
    logic                r_out_knock;
    logic [ENERGY_W-1:0] r_out_energy;
    logic [THR_W-1:0]    r_out_thr;
    t_knock_state        r_out_ks;

    logic [SAMPLE_W-1:0] mag;
    logic [CNT_W:0]      div_sh;
    logic                div_ge;
    logic [CNT_W:0]      div_diff;
    logic [ENERGY_W-1:0] energy;

    logic [MIN_W-1:0]    n_wmin;
    logic [ENERGY_W-1:0] n_nf;
    logic [TIME_W-1:0]   n_wstart;
    logic [MIN_W-1:0]    wmin_mid;
    logic [PROD_W-1:0]   prod;

    t_knock_state        ks_gated;
    t_knock_state        n_ks;
    logic                n_in_burst;
    logic [TIME_W-1:0]   n_bstart;
    logic [TIME_W-1:0]   n_lkt;
    logic                n_knock;
    logic [TIME_W-1:0]   burst_len;
    logic [TIME_W-1:0]   gap_start;
    logic [TIME_W-1:0]   since_knock;

    // |sample|; the most negative code maps to 32768
    assign mag = i_sample[SAMPLE_W-1] ? (~i_sample + 1'b1) : i_sample;

    // restoring divide, one quotient bit per cycle
    assign div_sh   = {r_rem, r_sum[SUM_W-1]};
    assign div_ge   = div_sh >= {1'b0, r_cnt};
    assign div_diff = div_sh - {1'b0, r_cnt};
    assign energy   = r_sum[ENERGY_W-1:0];

    always_comb begin
        n_nf     = r_nf;
        n_wstart = r_wstart;
        wmin_mid = r_wmin;
        if ((r_now - r_wstart) >= {16'd0, i_cfg.floor_window_ms}) begin
            n_wstart = r_now;
            if (r_wmin != '0 && r_wmin != MIN_NONE) n_nf = r_wmin[ENERGY_W-1:0];
            wmin_mid = MIN_NONE;
        end
        n_wmin = ({1'b0, energy} < wmin_mid) ? {1'b0, energy} : wmin_mid;
    end

    assign prod = PROD_W'(r_nf * i_cfg.threshold_gain);

    always_comb begin
        ks_gated    = (!r_chat && r_ks == KS_ARMED) ? KS_IDLE : r_ks;
        n_ks        = ks_gated;
        n_in_burst  = r_in_burst;
        n_bstart    = r_bstart;
        n_lkt       = r_lkt;
        n_knock     = 1'b0;
        burst_len   = r_now - r_bstart;
        gap_start   = r_bstart - r_lkt;
        since_knock = r_now - r_lkt;
        if (ks_gated == KS_COOLDOWN) begin
            if (since_knock >= {16'd0, i_cfg.cooldown_ms}) n_ks = KS_IDLE;
        end else if ({8'd0, energy} <= r_thr) begin
            if (r_in_burst) begin
                n_in_burst = 1'b0;
                n_bstart   = '0;
                if (burst_len <= {16'd0, i_cfg.max_burst_ms}) begin
                    if (ks_gated == KS_ARMED && gap_start >= {16'd0, i_cfg.min_gap_ms}) begin
                        n_knock = 1'b1;
                        n_ks    = KS_COOLDOWN;
                        n_lkt   = r_now;
                    end else begin
                        n_ks  = KS_ARMED;
                        n_lkt = r_bstart;
                    end
                end
            end
        end else if (!r_in_burst) begin
            n_in_burst = 1'b1;
            n_bstart   = r_now;
            if (ks_gated == KS_ARMED && since_knock > {16'd0, i_cfg.max_gap_ms}) begin
                n_ks = KS_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_cnt       <= '0;
            r_rem       <= '0;
            r_step      <= '0;
            r_nf        <= '0;
            r_wmin      <= MIN_NONE;
            r_wstart    <= '0;
            r_ks        <= KS_IDLE;
            r_in_burst  <= 1'b0;
            r_bstart    <= '0;
            r_lkt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accum && r_cnt < CNT_W'(MAX_SLICE_SAMPLES)) begin
                r_sum <= r_sum + SUM_W'(mag);
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.start) begin
                r_rem  <= '0;
                r_step <= '0;
            end
            if (i_cmd.div_step) begin
                r_sum  <= {r_sum[SUM_W-2:0], div_ge};
                r_rem  <= div_ge ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.win_upd) begin
                r_nf     <= n_nf;
                r_wstart <= n_wstart;
                r_wmin   <= n_wmin;
            end
            if (i_cmd.finish) begin
                r_sum       <= '0;
                r_cnt       <= '0;
                r_ks        <= n_ks;
                r_in_burst  <= n_in_burst;
                r_bstart    <= n_bstart;
                r_lkt       <= n_lkt;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_now  <= i_time_ms;
            r_chat <= i_chat_idle;
        end
        if (i_cmd.thr_calc) begin
            r_thr <= (prod < {8'd0, i_cfg.threshold_minimum}) ?
                     {8'd0, i_cfg.threshold_minimum} : prod;
        end
        if (i_cmd.finish) begin
            r_out_knock  <= n_knock;
            r_out_energy <= energy;
            r_out_thr    <= r_thr[THR_W-1:0];
            r_out_ks     <= n_ks;
        end
    end

    assign o_stat.div_done = r_step == STEP_W'(SUM_W - 1);
    assign o_stat.out_free = !r_out_valid || o_res.ready;

    assign o_res.valid            = r_out_valid;
    assign o_res.knock_detected   = r_out_knock;
    assign o_res.slice_energy     = r_out_energy;
    assign o_res.hit_threshold    = r_out_thr;
    assign o_res.recognizer_state = r_out_ks;

    `DKD_ASSERT_NOW(a_knock_enters_cooldown, r_out_valid && r_out_knock, r_out_ks == KS_COOLDOWN, "knock reported outside cooldown")
    `DKD_ASSERT_NOW(a_count_bounded, 1'b1, r_cnt <= CNT_W'(MAX_SLICE_SAMPLES), "slice count beyond bound")
    `DKD_ASSERT_NOW(a_no_burst_in_cooldown, r_in_burst, r_ks != KS_COOLDOWN, "burst tracked in cooldown")
    `DKD_ASSERT_NEXT(a_finish_clears, i_cmd.finish, r_cnt == '0 && r_out_valid, "slice not closed after result")

endmodule

`default_nettype wire

>>> design/double_knock_detector_unit.sv
// Channel | Dir | Payload                                                  | Handshake
// i_smp   | in  | sample, last_in_slice, time_ms, chat_idle                | valid/ready
// o_res   | out | knock_detected, slice_energy, hit_threshold, recog. state | valid/ready
// i_cfg_* | in  | 3-bit index, 16-bit data                                 | write enable
//
// A sample that is not the last of its slice is taken at once: input ready is high while a slice is gathered.
// The last sample starts the serial divider for the mean, which gives one quotient
// bit per cycle; then come the window, threshold and recognizer steps. Input ready
// is low throughout that stretch.
// The result sits in an output register; a further stall holds the recognizer
// step until that register is free. Synchronous active-low reset, no clearing pass.
`default_nettype none

module double_knock_detector_unit
    import dkd_pkg::*;
#(
    parameter int MAX_SLICE_SAMPLES = MAX_SLICE_SAMPLES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    dkd_in_if.sink                     i_smp,
    dkd_out_if.source                  o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    dkd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    dkd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .i_in_last  (i_smp.last_in_slice),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    assign i_smp.ready = in_ready;

    dkd_datapath #(
        .MAX_SLICE_SAMPLES (MAX_SLICE_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_sample    (i_smp.sample),
        .i_time_ms   (i_smp.time_ms),
        .i_chat_idle (i_smp.chat_idle),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

>>> dv/double_knock_detector_unit_tb.sv
`default_nettype none

module double_knock_detector_unit_tb;
    import dkd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned DRAIN_LIMIT  = 20_000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int unsigned PHASE_ITEMS  = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic                knock;
        logic [ENERGY_W-1:0] energy;
        logic [THR_W-1:0]    threshold;
        logic [1:0]          state;
    } t_slice_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dkd_in_if  smp_ch ();
    dkd_out_if res_ch ();

    double_knock_detector_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // detector state as the block should hold it
    t_cfg          cfg_q;
    logic [25:0]   acc_sum;
    logic [10:0]   acc_cnt;
    logic [15:0]   floor_q;
    logic [MIN_W-1:0] win_min;
    logic [31:0]   win_start;
    t_knock_state  kstate;
    logic          burst_on;
    logic [31:0]   burst_t0;
    logic [31:0]   knock_t;

    t_slice_result expected_slices[$];
    t_slice_result want;

    int unsigned err_count     = 0;
    int unsigned items_sent    = 0;
    int unsigned cycle_count   = 0;
    int unsigned hold_requests = 0;
    bit          tx_gaps       = 1'b1;
    bit          rx_gaps       = 1'b1;
    logic [31:0] now_ms        = '0;

    task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                   input longint unsigned got_v);
        err_count++;
        $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
    endtask

    task automatic reset_model();
        cfg_q.floor_window_ms   = FLOOR_WINDOW_RST;
        cfg_q.threshold_gain    = GAIN_RST;
        cfg_q.threshold_minimum = THR_MIN_RST;
        cfg_q.max_burst_ms      = MAX_BURST_RST;
        cfg_q.min_gap_ms        = MIN_GAP_RST;
        cfg_q.max_gap_ms        = MAX_GAP_RST;
        cfg_q.cooldown_ms       = COOLDOWN_RST;
        acc_sum   = '0;
        acc_cnt   = '0;
        floor_q   = '0;
        win_min   = MIN_NONE;
        win_start = '0;
        kstate    = KS_IDLE;
        burst_on  = 1'b0;
        burst_t0  = '0;
        knock_t   = '0;
    endtask

    task automatic predict_sample(input logic [15:0] smp, input logic is_last,
                                  input logic [31:0] t, input logic chat);
        logic [16:0]   mag;
        logic [31:0]   energy;
        logic [31:0]   thr;
        logic          knock;
        t_slice_result res;
        mag = smp[15] ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
        if (acc_cnt < MAX_SLICE_SAMPLES_DEF) begin
            acc_sum = acc_sum + mag;
            acc_cnt = acc_cnt + 1'b1;
        end
        if (is_last) begin
            energy  = 32'(acc_sum) / 32'(acc_cnt);
            acc_sum = '0;
            acc_cnt = '0;
            if (!chat && kstate == KS_ARMED)
                kstate = KS_IDLE;
            if (32'(t - win_start) >= 32'(cfg_q.floor_window_ms)) begin
                win_start = t;
                // a zero or empty minimum leaves the floor as it was
                if (win_min != '0 && win_min != MIN_NONE)
                    floor_q = win_min[15:0];
                win_min = MIN_NONE;
            end
            if (energy < 32'(win_min))
                win_min = energy[MIN_W-1:0];
            thr = 32'(floor_q) * 32'(cfg_q.threshold_gain);
            if (thr < 32'(cfg_q.threshold_minimum))
                thr = 32'(cfg_q.threshold_minimum);
            knock = 1'b0;
            if (kstate == KS_COOLDOWN) begin
                if (32'(t - knock_t) >= 32'(cfg_q.cooldown_ms))
                    kstate = KS_IDLE;
            end else if (energy <= thr) begin
                if (burst_on) begin
                    burst_on = 1'b0;
                    if (32'(t - burst_t0) <= 32'(cfg_q.max_burst_ms)) begin
                        if (kstate == KS_ARMED &&
                            32'(burst_t0 - knock_t) >= 32'(cfg_q.min_gap_ms)) begin
                            knock   = 1'b1;
                            kstate  = KS_COOLDOWN;
                            knock_t = t;
                        end else begin
                            kstate  = KS_ARMED;
                            knock_t = burst_t0;
                        end
                    end
                    burst_t0 = '0;
                end
            end else if (!burst_on) begin
                burst_on = 1'b1;
                burst_t0 = t;
                if (kstate == KS_ARMED && 32'(t - knock_t) > 32'(cfg_q.max_gap_ms))
                    kstate = KS_IDLE;
            end
            res.knock     = knock;
            res.energy    = energy[ENERGY_W-1:0];
            res.threshold = thr[THR_W-1:0];
            res.state     = kstate;
            expected_slices.push_back(res);
        end
    endtask

    // input side monitor
    always @(posedge i_clk) begin
        if (i_rst_n && smp_ch.valid && smp_ch.ready)
            predict_sample(smp_ch.sample, smp_ch.last_in_slice, smp_ch.time_ms,
                           smp_ch.chat_idle);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_slices.size() == 0) begin
                report_mismatch("result with no slice pending", 0, 0);
            end else begin
                want = expected_slices.pop_front();
                if (res_ch.knock_detected !== want.knock)
                    report_mismatch("knock_detected", want.knock, res_ch.knock_detected);
                if (res_ch.slice_energy !== want.energy)
                    report_mismatch("slice_energy", want.energy, res_ch.slice_energy);
                if (res_ch.hit_threshold !== want.threshold)
                    report_mismatch("hit_threshold", want.threshold, res_ch.hit_threshold);
                if (res_ch.recognizer_state !== want.state)
                    report_mismatch("recognizer_state", want.state, res_ch.recognizer_state);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // result side: random stalls plus the long hold-off on request
    initial begin : rx_side
        int unsigned stall;
        int unsigned hold;
        int unsigned holds_done;
        res_ch.ready <= 1'b0;
        stall      = 0;
        hold       = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                hold       = HOLD_CYCLES;
            end
            if (hold != 0) begin
                hold--;
                res_ch.ready <= 1'b0;
            end else if (stall != 0) begin
                stall--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if (rx_gaps && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    function automatic logic [15:0] make_sample(input int unsigned lo, input int unsigned hi);
        int m;
        m = $urandom_range(hi, lo);
        if (m == 32768 || $urandom_range(0, 1) == 1)
            return 16'(-m);
        return 16'(m);
    endfunction

    function automatic int unsigned slice_len();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(7, 40);
        return $urandom_range(1, 6);
    endfunction

    function automatic logic chat_roll();
        return $urandom_range(0, 9) != 0;
    endfunction

    // valid stays high between back-to-back requests; in this task it is lowered only for a gap
    task automatic send_sample(input logic [15:0] smp, input logic is_last,
                               input logic [31:0] t, input logic chat);
        int unsigned gap;
        gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap != 0) begin
            smp_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_ch.valid         <= 1'b1;
        smp_ch.sample        <= smp;
        smp_ch.last_in_slice <= is_last;
        smp_ch.time_ms       <= t;
        smp_ch.chat_idle     <= chat;
        @(posedge i_clk);
        while (!smp_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_slice(input int unsigned n, input int unsigned lo, input int unsigned hi,
                              input logic [31:0] t, input logic chat);
        for (int unsigned k = 1; k < n; k++)
            send_sample(make_sample(lo, hi), 1'b0, $urandom, 1'($urandom));
        send_sample(make_sample(lo, hi), 1'b1, t, chat);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FLOOR_WINDOW: cfg_q.floor_window_ms   = data;
            CFG_GAIN:         cfg_q.threshold_gain    = data[7:0];
            CFG_THR_MIN:      cfg_q.threshold_minimum = data;
            CFG_MAX_BURST:    cfg_q.max_burst_ms      = data;
            CFG_MIN_GAP:      cfg_q.min_gap_ms        = data;
            CFG_MAX_GAP:      cfg_q.max_gap_ms        = data;
            CFG_COOLDOWN:     cfg_q.cooldown_ms       = data;
            default: ;
        endcase
    endtask

    task automatic end_phase();
        int unsigned waited;
        smp_ch.valid <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (expected_slices.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_slices.size() != 0)
            report_mismatch("slices never answered", 0, expected_slices.size());
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_default_double_knock();
        send_slice(1, 0, 0, 32'd10, 1'b1);
        send_slice(1, 0, 0, 32'd1010, 1'b1);      // window shuts on a zero minimum
        send_slice(1, 32767, 32767, 32'd1030, 1'b1);
        send_slice(1, 0, 0, 32'd1060, 1'b1);      // short burst arms
        send_slice(1, 30000, 30000, 32'd1300, 1'b1);
        send_slice(1, 0, 0, 32'd1320, 1'b1);      // second knock confirmed
        send_slice(1, 32767, 32767, 32'd1400, 1'b1);
        send_slice(1, 0, 0, 32'd2900, 1'b1);      // cooldown elapsed
        now_ms = 32'd2900;
        end_phase();
    endtask

    task automatic test_chat_and_gap();
        send_slice(1, 20000, 20000, 32'd3000, 1'b1);
        send_slice(1, 0, 0, 32'd3020, 1'b1);
        send_slice(1, 0, 0, 32'd3040, 1'b0);      // busy chat drops the armed state
        send_slice(1, 20000, 20000, 32'd3100, 1'b1);
        send_slice(1, 0, 0, 32'd3120, 1'b1);
        send_slice(1, 20000, 20000, 32'd4000, 1'b1); // gap too long
        send_slice(1, 0, 0, 32'd4020, 1'b1);
        now_ms = 32'd4020;
        end_phase();
    endtask

    task automatic test_field_extremes();
        send_sample(16'h8000, 1'b0, 32'hFFFF_FFFF, 1'b0);
        send_sample(16'h7FFF, 1'b0, 32'h0000_0000, 1'b1);
        send_sample(16'h0000, 1'b1, 32'hFFFF_FFF0, 1'b1);
        send_sample(16'hFFFF, 1'b0, 32'h5555_AAAA, 1'b1);
        send_sample(16'h0001, 1'b0, 32'hAAAA_5555, 1'b0);
        send_sample(16'h8000, 1'b1, 32'h0000_0010, 1'b0);  // clock has wrapped
        now_ms = 32'h0000_0010;
        end_phase();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_FLOOR_WINDOW, 16'd1);
        write_reg(CFG_GAIN, 16'hFF00);            // upper byte dropped, gain of zero
        write_reg(CFG_THR_MIN, 16'd0);
        write_reg(CFG_MAX_BURST, 16'hFFFF);
        write_reg(CFG_MIN_GAP, 16'd0);
        write_reg(CFG_MAX_GAP, 16'hFFFF);
        write_reg(CFG_COOLDOWN, 16'd0);
        write_reg(CFG_UNUSED_IDX, 16'hA5A5);      // no such register
        send_slice(2, 5, 5, now_ms + 10, 1'b1);
        send_slice(1, 0, 0, now_ms + 20, 1'b1);
        send_slice(1, 32767, 32767, now_ms + 30, 1'b1);
        send_slice(1, 0, 0, now_ms + 40, 1'b1);
        send_slice(1, 32768, 32768, now_ms + 50, 1'b1);
        send_slice(1, 0, 0, now_ms + 60, 1'b1);
        send_slice(1, 0, 0, now_ms + 60, 1'b1);
        now_ms += 60;
        end_phase();
        write_reg(CFG_FLOOR_WINDOW, 16'hFFFF);
        write_reg(CFG_GAIN, 16'h00FF);
        write_reg(CFG_THR_MIN, 16'hFFFF);
        write_reg(CFG_MAX_BURST, 16'd0);
        write_reg(CFG_MIN_GAP, 16'hFFFF);
        write_reg(CFG_MAX_GAP, 16'd0);
        write_reg(CFG_COOLDOWN, 16'hFFFF);
        send_slice(1, 32768, 32768, now_ms + 10, 1'b1);
        send_slice(2, 0, 40, now_ms + 70000, 1'b1);
        now_ms += 70000;
        end_phase();
    endtask

    task automatic test_slice_overflow();
        tx_gaps = 1'b0;
        // the extra samples past the bound must not move the mean
        repeat (MAX_SLICE_SAMPLES_DEF) send_sample(16'h8000, 1'b0, $urandom, 1'($urandom));
        repeat (5) send_sample(16'h7FFF, 1'b0, $urandom, 1'($urandom));
        now_ms += 25;
        send_sample(16'h7FFF, 1'b1, now_ms, 1'b1);
        end_phase();
        tx_gaps = 1'b1;
    endtask

    task automatic test_output_stall();
        tx_gaps = 1'b0;
        // results are held back so slice requests pile up behind the output register
        hold_requests++;
        repeat (10) begin
            now_ms += $urandom_range(5, 40);
            send_slice(1, 0, 32768, now_ms, chat_roll());
        end
        end_phase();
        tx_gaps = 1'b1;
    endtask

    function automatic logic [15:0] pick_reg(input int unsigned lo, input int unsigned hi,
                                             input logic [15:0] low_end);
        case ($urandom_range(0, 7))
            0: return low_end;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic randomize_config();
        logic [7:0] gain;
        case ($urandom_range(0, 5))
            0: gain = 8'd0;
            1: gain = 8'd255;
            default: gain = 8'($urandom_range(1, 16));
        endcase
        write_reg(CFG_FLOOR_WINDOW, pick_reg(50, 3000, 16'd1));
        write_reg(CFG_GAIN, {8'($urandom), gain});
        write_reg(CFG_THR_MIN, pick_reg(100, 3000, 16'd0));
        write_reg(CFG_MAX_BURST, pick_reg(20, 300, 16'd0));
        write_reg(CFG_MIN_GAP, pick_reg(30, 300, 16'd0));
        write_reg(CFG_MAX_GAP, pick_reg(200, 1500, 16'd0));
        write_reg(CFG_COOLDOWN, pick_reg(50, 2000, 16'd0));
        write_reg(CFG_UNUSED_IDX, 16'($urandom));
    endtask

    task automatic knock_sequence();
        logic [31:0] s1;
        logic [31:0] t1;
        logic [31:0] t2;
        int unsigned len_lim;
        int unsigned gap_lo;
        int unsigned gap_hi;
        int unsigned quiet;
        quiet   = $urandom_range(0, 60);
        len_lim = (cfg_q.max_burst_ms > 400) ? 400 : cfg_q.max_burst_ms + 20;
        gap_lo  = (cfg_q.min_gap_ms > 20) ? cfg_q.min_gap_ms - 20 : 0;
        gap_hi  = (cfg_q.max_gap_ms > 2980) ? 3000 : cfg_q.max_gap_ms + 20;
        repeat ($urandom_range(1, 3)) begin
            now_ms += $urandom_range(10, 60);
            send_slice(slice_len(), 0, quiet, now_ms, chat_roll());
        end
        now_ms += $urandom_range(10, 60);
        s1 = now_ms;
        send_slice(slice_len(), 2000, 32768, s1, chat_roll());
        t1 = s1 + $urandom_range(0, len_lim);
        if (t1 - s1 > 30 && $urandom_range(0, 2) == 0)
            send_slice(slice_len(), 2000, 32768, s1 + (t1 - s1) / 2, chat_roll());
        send_slice(slice_len(), 0, quiet, t1, chat_roll());
        t2 = s1 + $urandom_range(gap_hi, gap_lo);
        if (t2 <= t1)
            t2 = t1 + $urandom_range(1, 20);
        if (t2 - t1 > 40)
            send_slice(slice_len(), 0, quiet, t1 + (t2 - t1) / 2, chat_roll());
        send_slice(slice_len(), 2000, 32768, t2, chat_roll());
        now_ms = t2 + $urandom_range(0, len_lim);
        send_slice(slice_len(), 0, quiet, now_ms, chat_roll());
        repeat ($urandom_range(0, 3)) begin
            now_ms += $urandom_range(10, 800);
            send_slice(slice_len(), 0, quiet, now_ms, chat_roll());
        end
    endtask

    task automatic noise_burst();
        logic is_last;
        repeat ($urandom_range(1, 12)) begin
            is_last = ($urandom_range(0, 2) == 0);
            if (is_last)
                now_ms += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 100);
            send_sample(16'($urandom), is_last, is_last ? now_ms : 32'($urandom),
                        1'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        int unsigned start;
        int unsigned phase_end;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            randomize_config();
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_gaps   = ($urandom_range(0, 3) != 0);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 4) == 0)
                    noise_burst();
                else
                    knock_sequence();
            end
            end_phase();
        end
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= '0;
        i_cfg_data           <= '0;
        smp_ch.valid         <= 1'b0;
        smp_ch.sample        <= '0;
        smp_ch.last_in_slice <= 1'b0;
        smp_ch.time_ms       <= '0;
        smp_ch.chat_idle     <= 1'b0;
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_double_knock();
        test_chat_and_gap();
        test_field_extremes();
        test_register_extremes();
        test_slice_overflow();
        test_output_stall();
        test_random_traffic();
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
